// ===== rtl/abpg_pkg.sv =====
package abpg_pkg;

    // Siren ramp length in steps (one way); pairs per siren cycle is twice this
    localparam int SirenStepsDefault = 10;

    localparam int DurW     = 32;
    localparam int SegIdxW  = 5;
    localparam int SegTimeW = 10;
    localparam int PatW     = 3;
    // Half position = 2 * pair + half, with room for two steps past the last half
    localparam int PosW     = SegIdxW + 2;

    typedef enum logic [1:0] {
        ActTick       = 2'd0,
        ActStart      = 2'd1,
        ActStop       = 2'd2,
        ActSetPattern = 2'd3
    } t_action;

    localparam logic [PatW-1:0] PatContinuous   = 3'd0;
    localparam logic [PatW-1:0] PatPulse        = 3'd1;
    localparam logic [PatW-1:0] PatSiren        = 3'd2;
    localparam logic [PatW-1:0] PatIntermittent = 3'd3;
    localparam logic [PatW-1:0] PatEmergency    = 3'd4;

    localparam logic [SegTimeW-1:0] ContinuousOnMs   = 10'd100;
    localparam logic [SegTimeW-1:0] PulseHalfMs      = 10'd500;
    localparam logic [SegTimeW-1:0] IntermitOnMs     = 10'd200;
    localparam logic [SegTimeW-1:0] IntermitOffMs    = 10'd800;
    localparam logic [SegTimeW-1:0] EmergencyHalfMs  = 10'd100;
    localparam logic [SegTimeW-1:0] SirenBaseMs      = 10'd50;
    localparam logic [SegTimeW-1:0] SirenStepMs      = 10'd20;
    localparam logic [SegTimeW-1:0] SilentOffMs      = 10'd1;

    typedef struct packed {
        logic                running;
        logic [PatW-1:0]     cur_pattern;
        logic [PatW-1:0]     cyc_pattern;
        logic [DurW-1:0]     alarm_length;
        logic [DurW-1:0]     elapsed_ms;
        logic [SegIdxW-1:0]  seg_index;
        logic [SegTimeW-1:0] seg_time;
        logic                sounding;
    } t_state;

    typedef struct packed {
        logic pin_level;
        logic alarm_active;
        logic expired;
    } t_result;

endpackage

// ===== rtl/abpg_next.sv =====
module abpg_next #(
    parameter int SIREN_STEPS = abpg_pkg::SirenStepsDefault
) (
    input  abpg_pkg::t_state                  i_state,
    input  logic [1:0]                        i_action,
    input  logic [abpg_pkg::PatW-1:0]         i_pattern,
    input  logic [abpg_pkg::DurW-1:0]         i_duration_ms,
    input  logic                              i_polarity,
    output abpg_pkg::t_state                  o_state,
    output abpg_pkg::t_result                 o_result
);

    localparam int PosW = abpg_pkg::PosW;
    localparam logic [PosW-2:0] SirenPairs = (PosW-1)'(2 * SIREN_STEPS);
    localparam logic [PosW-2:0] SirenSteps = (PosW-1)'(SIREN_STEPS);
    localparam logic [PosW-1:0] SirenEnd   = PosW'(4 * SIREN_STEPS);
    localparam logic [PosW-1:0] PlainEnd   = PosW'(2);

    // Length of the half at a position; zero means the half is skipped
    function automatic logic [abpg_pkg::SegTimeW-1:0] half_len(
        input logic [abpg_pkg::PatW-1:0] pat,
        input logic [PosW-1:0]           pos
    );
        logic [PosW-2:0]                 pair;
        logic [PosW-2:0]                 step;
        logic [abpg_pkg::SegTimeW-1:0]   step_ext;
        logic [abpg_pkg::SegTimeW-1:0]   len;
        pair     = pos[PosW-1:1];
        step     = (pair < SirenSteps) ? pair : SirenPairs - pair;
        step_ext = abpg_pkg::SegTimeW'(step);
        case (pat)
            abpg_pkg::PatContinuous: begin
                len = pos[0] ? '0 : abpg_pkg::ContinuousOnMs;
            end
            abpg_pkg::PatPulse: begin
                len = abpg_pkg::PulseHalfMs;
            end
            abpg_pkg::PatSiren: begin
                len = abpg_pkg::SirenBaseMs + abpg_pkg::SirenStepMs * step_ext;
            end
            abpg_pkg::PatIntermittent: begin
                len = pos[0] ? abpg_pkg::IntermitOffMs : abpg_pkg::IntermitOnMs;
            end
            abpg_pkg::PatEmergency: begin
                len = abpg_pkg::EmergencyHalfMs;
            end
            default: begin
                len = pos[0] ? abpg_pkg::SilentOffMs : '0;
            end
        endcase
        return len;
    endfunction

    function automatic logic half_ok(
        input logic [abpg_pkg::PatW-1:0] pat,
        input logic [PosW-1:0]           pos
    );
        logic [PosW-1:0] pos_end;
        pos_end = (pat == abpg_pkg::PatSiren) ? SirenEnd : PlainEnd;
        return (pos < pos_end) && (half_len(pat, pos) != '0);
    endfunction

    abpg_pkg::t_action              action;
    logic [PosW-1:0]                cur_pos;
    logic [PosW-1:0]                pos_a;
    logic [PosW-1:0]                pos_b;
    logic [abpg_pkg::SegTimeW-1:0]  seg_t1;
    logic [abpg_pkg::DurW-1:0]      elapsed_inc;
    logic                           half_done;
    logic                           ok_a;
    logic                           ok_b;
    logic [abpg_pkg::PatW-1:0]      begin_pat;
    logic                           ok_first;
    logic                           expiry_hit;
    logic                           do_begin;
    logic                           expired;
    abpg_pkg::t_state               n;

    assign action      = abpg_pkg::t_action'(i_action);
    assign cur_pos     = {1'b0, i_state.seg_index, ~i_state.sounding};
    assign pos_a       = cur_pos + PosW'(1);
    assign pos_b       = cur_pos + PosW'(2);
    assign seg_t1      = i_state.seg_time + abpg_pkg::SegTimeW'(1);
    assign elapsed_inc = (&i_state.elapsed_ms) ? i_state.elapsed_ms
                                               : i_state.elapsed_ms + abpg_pkg::DurW'(1);
    assign half_done   = seg_t1 >= half_len(i_state.cyc_pattern, cur_pos);
    // No pattern skips two halves in a row, so two candidates cover the search
    assign ok_a        = half_ok(i_state.cyc_pattern, pos_a);
    assign ok_b        = half_ok(i_state.cyc_pattern, pos_b);
    assign begin_pat   = (action == abpg_pkg::ActStart) ? i_pattern : i_state.cur_pattern;
    assign ok_first    = half_ok(begin_pat, PosW'(0));
    // Start clears elapsed time, so only a tick can reach the limit
    assign expiry_hit  = (action == abpg_pkg::ActTick) && (i_state.alarm_length != '0)
                         && (elapsed_inc >= i_state.alarm_length);

    always_comb begin
        n        = i_state;
        do_begin = 1'b0;
        expired  = 1'b0;
        case (action)
            abpg_pkg::ActTick: begin
                if (i_state.running) begin
                    n.elapsed_ms = elapsed_inc;
                    n.seg_time   = seg_t1;
                    if (half_done) begin
                        if (ok_a) begin
                            n.seg_index = pos_a[PosW-2:1];
                            n.sounding  = ~pos_a[0];
                            n.seg_time  = '0;
                        end else if (ok_b) begin
                            n.seg_index = pos_b[PosW-2:1];
                            n.sounding  = ~pos_b[0];
                            n.seg_time  = '0;
                        end else begin
                            do_begin = 1'b1;
                        end
                    end
                end
            end
            abpg_pkg::ActStart: begin
                n.running      = 1'b1;
                n.cur_pattern  = i_pattern;
                n.alarm_length = i_duration_ms;
                n.elapsed_ms   = '0;
                do_begin       = 1'b1;
            end
            abpg_pkg::ActStop: begin
                n.running   = 1'b0;
                n.sounding  = 1'b0;
                n.seg_index = '0;
                n.seg_time  = '0;
            end
            abpg_pkg::ActSetPattern: begin
                n.cur_pattern = i_pattern;
            end
            default: begin
                n = i_state;
            end
        endcase

        if (do_begin) begin
            if (expiry_hit) begin
                n.running   = 1'b0;
                n.sounding  = 1'b0;
                n.seg_index = '0;
                n.seg_time  = '0;
                expired     = 1'b1;
            end else begin
                // Latch the pattern, open on the first half that is not skipped
                n.cyc_pattern = begin_pat;
                n.seg_index   = '0;
                n.sounding    = ok_first;
                n.seg_time    = '0;
            end
        end
    end

    assign o_state                = n;
    assign o_result.pin_level     = n.sounding ? i_polarity : ~i_polarity;
    assign o_result.alarm_active  = n.running;
    assign o_result.expired       = expired;

endmodule

// ===== rtl/alarm_buzzer_pattern_generator_core.sv =====
// Channel   Direction  Handshake                 Beat payload
// -------   ---------  ------------------------  ----------------------------------
// in        input      i_in_valid / o_in_stall   i_action, i_pattern, i_duration_ms
// out       output     o_out_valid / i_out_stall o_pin_level, o_alarm_active, o_expired
// cfg       input      i_cfg_we                  i_cfg_wdata (pin polarity)
//
// One beat in, one beat out; a new beat is taken every clock while the output moves.
// Each beat passes the input register, one pass of next-state logic, then the state and
// result registers; that pass sets the rate. Reset (synchronous, i_rst_n low) silences
// the alarm, clears alarm state and valid flags and sets the polarity to active high.
// A stall on the output holds the result register and, through o_in_stall, the input
// register; nothing is dropped.
module alarm_buzzer_pattern_generator_core #(
    parameter int SIREN_STEPS = abpg_pkg::SirenStepsDefault
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,

    input  logic                          i_cfg_we,
    input  logic                          i_cfg_wdata,

    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [1:0]                    i_action,
    input  logic [abpg_pkg::PatW-1:0]     i_pattern,
    input  logic [abpg_pkg::DurW-1:0]     i_duration_ms,

    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_pin_level,
    output logic                          o_alarm_active,
    output logic                          o_expired
);

    // Input register
    logic                          r_in_valid;
    logic [1:0]                    r_in_action;
    logic [abpg_pkg::PatW-1:0]     r_in_pattern;
    logic [abpg_pkg::DurW-1:0]     r_in_duration;

    // Alarm state and polarity
    abpg_pkg::t_state              r_state;
    abpg_pkg::t_state              n_state;
    logic                          r_polarity;

    // Result register
    logic                          r_out_valid;
    abpg_pkg::t_result             r_result;
    abpg_pkg::t_result             n_result;

    logic                          out_free;
    logic                          proc;
    logic                          in_take;

    // The result slot frees when empty or when its beat leaves this clock
    assign out_free   = !r_out_valid || !i_out_stall;
    assign proc       = r_in_valid && out_free;
    assign in_take    = i_in_valid && (!r_in_valid || out_free);
    assign o_in_stall = r_in_valid && !out_free;

    abpg_next #(
        .SIREN_STEPS (SIREN_STEPS)
    ) u_next (
        .i_state       (r_state),
        .i_action      (r_in_action),
        .i_pattern     (r_in_pattern),
        .i_duration_ms (r_in_duration),
        .i_polarity    (r_polarity),
        .o_state       (n_state),
        .o_result      (n_result)
    );

    // Control: valid flags, alarm state, polarity
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
            r_polarity  <= 1'b1;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (proc) begin
                r_in_valid <= 1'b0;
            end
            if (proc) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (out_free) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                r_polarity <= i_cfg_wdata;
            end
        end
    end

    // Payload: hold the input beat until processed, hold the result while stalled
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_action   <= i_action;
            r_in_pattern  <= i_pattern;
            r_in_duration <= i_duration_ms;
        end
        if (proc) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_pin_level    = r_result.pin_level;
    assign o_alarm_active = r_result.alarm_active;
    assign o_expired      = r_result.expired;

endmodule
